// ----- rtl/mtc_pkg.sv -----
// Package for the MIDI timecode tracker: item layout, opcode and carry codes,
// timecode limits and the reciprocal constants of the count-to-digit split.
// No dependencies.
`timescale 1ns / 1ps

package mtc_pkg;

  // Opcodes of an input word.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_LOAD = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  // Highest rollover caused by a quarter-frame tick.
  typedef enum logic [2:0] {
    CARRY_NONE   = 3'd0,
    CARRY_FRAME  = 3'd1,
    CARRY_SECOND = 3'd2,
    CARRY_MINUTE = 3'd3,
    CARRY_HOUR   = 3'd4
  } carry_t;

  // Timecode limits.
  localparam logic [5:0] FRAMES_PER_SECOND  = 6'd30;
  localparam logic [6:0] SECONDS_PER_MINUTE = 7'd60;
  localparam logic [6:0] MINUTES_PER_HOUR   = 7'd60;
  localparam logic [5:0] HOURS_PER_CYCLE    = 6'd32;
  localparam logic [4:0] HOUR_MASK          = 5'h1f;

  // Quarter-frame counts per unit.
  localparam logic [6:0]  QF_PER_SECOND = 7'd120;
  localparam logic [12:0] QF_PER_MINUTE = 13'd7200;
  localparam logic [18:0] QF_PER_HOUR   = 19'd432000;
  localparam logic [23:0] QF_CYCLE      = 24'd13824000;

  // Reciprocals for exact division: floor(x / d) = (x * ceil(2^s / d)) >> s
  // holds for all x below 2^n when s = n + ceil(log2(d)).
  localparam int HOUR_SHIFT = 43;
  localparam int MIN_SHIFT  = 32;
  localparam int SEC_SHIFT  = 20;

  localparam logic [63:0] HOUR_RECIP_FULL =
    ((64'd1 << HOUR_SHIFT) + 64'(QF_PER_HOUR) - 64'd1) / 64'(QF_PER_HOUR);
  localparam logic [63:0] MIN_RECIP_FULL =
    ((64'd1 << MIN_SHIFT) + 64'(QF_PER_MINUTE) - 64'd1) / 64'(QF_PER_MINUTE);
  localparam logic [63:0] SEC_RECIP_FULL =
    ((64'd1 << SEC_SHIFT) + 64'(QF_PER_SECOND) - 64'd1) / 64'(QF_PER_SECOND);

  localparam logic [24:0] HOUR_RECIP = HOUR_RECIP_FULL[24:0];
  localparam logic [19:0] MIN_RECIP  = MIN_RECIP_FULL[19:0];
  localparam logic [13:0] SEC_RECIP  = SEC_RECIP_FULL[13:0];

  // Depth of the conversion pipeline.
  localparam int NUM_STAGES = 8;

  // One word as it travels through the conversion pipeline. For a load,
  // work and count hold partial sums of the linear count until it is final;
  // for a set, work holds the remainder still to be split into digits.
  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  frames;
    logic [23:0] count;
    logic [23:0] work;
  } item_t;

endpackage

// ----- rtl/mtc_convert.sv -----
// Conversion pipeline of the MIDI timecode tracker: computes the linear count
// of a full-frame load and splits a set count into digits, eight stages.
// Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_convert (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_stall,
  input  mtc_pkg::item_t up_item,
  output logic          down_valid,
  input  logic          down_ready,
  output mtc_pkg::item_t down_item
);

  logic [mtc_pkg::NUM_STAGES-1:0] v;
  logic [mtc_pkg::NUM_STAGES:0]   adv;
  mtc_pkg::item_t                 st  [mtc_pkg::NUM_STAGES];
  mtc_pkg::item_t                 nxt [mtc_pkg::NUM_STAGES];

  logic [48:0] prod_h;
  logic [38:0] prod_m;
  logic [26:0] prod_s;
  logic [23:0] sec_rem;
  logic [23:0] set_rebuild;

  // Bring a value below 2^24 into one 32-hour cycle.
  function automatic logic [23:0] reduce_cycle(input logic [23:0] x);
    return (x >= mtc_pkg::QF_CYCLE) ? x - mtc_pkg::QF_CYCLE : x;
  endfunction

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    adv[mtc_pkg::NUM_STAGES] = down_ready;
    for (int k = mtc_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign up_stall   = !adv[0];
  assign down_valid = v[mtc_pkg::NUM_STAGES-1];
  assign down_item  = st[mtc_pkg::NUM_STAGES-1];

  assign nxt[0] = up_item;

  // Stage 1: reduce a set count; form the hour and lower parts of a load.
  always_comb begin
    nxt[1] = st[0];
    unique case (st[0].op)
      mtc_pkg::OP_SET: begin
        nxt[1].count = reduce_cycle(st[0].count);
        nxt[1].work  = reduce_cycle(st[0].count);
      end
      mtc_pkg::OP_LOAD: begin
        nxt[1].work  = 24'(st[0].hours) * 24'(mtc_pkg::QF_PER_HOUR);
        nxt[1].count = 24'(st[0].minutes) * 24'(mtc_pkg::QF_PER_MINUTE)
                     + 24'(st[0].seconds) * 24'(mtc_pkg::QF_PER_SECOND)
                     + {17'd0, st[0].frames, 2'b00};
      end
      default: begin
      end
    endcase
  end

  // Stage 2: hours of a set count; sum of the load parts.
  assign prod_h = 49'(st[1].work) * 49'(mtc_pkg::HOUR_RECIP);

  always_comb begin
    nxt[2] = st[1];
    unique case (st[1].op)
      mtc_pkg::OP_SET:  nxt[2].hours = prod_h[mtc_pkg::HOUR_SHIFT +: 5];
      mtc_pkg::OP_LOAD: nxt[2].count = st[1].work + st[1].count;
      default: begin
      end
    endcase
  end

  // Stage 3: remainder below one hour; wrap of the load count.
  always_comb begin
    nxt[3] = st[2];
    unique case (st[2].op)
      mtc_pkg::OP_SET:
        nxt[3].work = st[2].work - 24'(st[2].hours) * 24'(mtc_pkg::QF_PER_HOUR);
      mtc_pkg::OP_LOAD: nxt[3].count = reduce_cycle(st[2].count);
      default: begin
      end
    endcase
  end

  // Stage 4: minutes of the remainder.
  assign prod_m = 39'(st[3].work[18:0]) * 39'(mtc_pkg::MIN_RECIP);

  always_comb begin
    nxt[4] = st[3];
    if (st[3].op == mtc_pkg::OP_SET) begin
      nxt[4].minutes = prod_m[mtc_pkg::MIN_SHIFT +: 6];
    end
  end

  // Stage 5: remainder below one minute.
  always_comb begin
    nxt[5] = st[4];
    if (st[4].op == mtc_pkg::OP_SET) begin
      nxt[5].work = st[4].work - 24'(st[4].minutes) * 24'(mtc_pkg::QF_PER_MINUTE);
    end
  end

  // Stage 6: seconds of the remainder.
  assign prod_s = 27'(st[5].work[12:0]) * 27'(mtc_pkg::SEC_RECIP);

  always_comb begin
    nxt[6] = st[5];
    if (st[5].op == mtc_pkg::OP_SET) begin
      nxt[6].seconds = prod_s[mtc_pkg::SEC_SHIFT +: 6];
    end
  end

  // Stage 7: remainder below one second gives the frame digit.
  assign sec_rem = st[6].work - 24'(st[6].seconds) * 24'(mtc_pkg::QF_PER_SECOND);

  always_comb begin
    nxt[7] = st[6];
    if (st[6].op == mtc_pkg::OP_SET) begin
      nxt[7].work   = sec_rem;
      nxt[7].frames = sec_rem[6:2];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= up_valid;
      end
      for (int k = 1; k < mtc_pkg::NUM_STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < mtc_pkg::NUM_STAGES; k++) begin
      if (adv[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Digits of a finished set put back together, for checking only.
  assign set_rebuild = 24'(down_item.hours) * 24'(mtc_pkg::QF_PER_HOUR)
                     + 24'(down_item.minutes) * 24'(mtc_pkg::QF_PER_MINUTE)
                     + 24'(down_item.seconds) * 24'(mtc_pkg::QF_PER_SECOND)
                     + {17'd0, down_item.frames, 2'b00};

  a_set_digits_in_range: assert property (@(posedge clk) disable iff (rst)
    down_valid && down_item.op == mtc_pkg::OP_SET |->
      7'(down_item.minutes) < mtc_pkg::MINUTES_PER_HOUR &&
      7'(down_item.seconds) < mtc_pkg::SECONDS_PER_MINUTE &&
      6'(down_item.frames) < mtc_pkg::FRAMES_PER_SECOND)
    else $error("set split produced a digit out of range");

  a_set_digits_match_count: assert property (@(posedge clk) disable iff (rst)
    down_valid && down_item.op == mtc_pkg::OP_SET |->
      down_item.count >= set_rebuild && (down_item.count - set_rebuild) < 24'd4)
    else $error("set digits do not match the linear count");

  a_load_count_wrapped: assert property (@(posedge clk) disable iff (rst)
    down_valid && down_item.op == mtc_pkg::OP_LOAD |->
      down_item.count < mtc_pkg::QF_CYCLE)
    else $error("load count not reduced into one cycle");

endmodule

// ----- rtl/mtc_state.sv -----
// Timecode state of the MIDI timecode tracker: applies ticks, loads and sets
// in order and holds the result word on the output channel.
// Depends on mtc_pkg.
`timescale 1ns / 1ps

module mtc_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  mtc_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [4:0]     hours,
  output logic [5:0]     minutes,
  output logic [5:0]     seconds,
  output logic [4:0]     frames,
  output logic [1:0]     quarter_phase,
  output logic [23:0]    linear_count,
  output logic [2:0]     carry_code
);

  logic [4:0]      hour_reg,   hour_next;
  logic [5:0]      minute_reg, minute_next;
  logic [5:0]      second_reg, second_next;
  logic [4:0]      frame_reg,  frame_next;
  logic [1:0]      phase_reg,  phase_next;
  logic [23:0]     count_reg,  count_next;
  mtc_pkg::carry_t carry_reg,  carry_next;

  logic [5:0]      tick_frame;
  logic [6:0]      tick_second;
  logic [6:0]      tick_minute;
  logic [5:0]      tick_hour;
  logic [23:0]     tick_count;
  mtc_pkg::carry_t tick_carry;
  logic            take;

  // The state registers are the result word; a new word enters once the
  // previous result has been taken.
  assign item_ready = !out_valid || !out_stall;
  assign take       = item_valid && item_ready;

  // Quarter-frame tick: advance the phase and carry through the digits.
  always_comb begin
    tick_frame  = {1'b0, frame_reg} + {5'd0, phase_reg == 2'd3};
    tick_second = {1'b0, second_reg};
    tick_minute = {1'b0, minute_reg};
    tick_hour   = {1'b0, hour_reg};
    tick_carry  = (phase_reg == 2'd3) ? mtc_pkg::CARRY_FRAME : mtc_pkg::CARRY_NONE;
    tick_count  = (count_reg == mtc_pkg::QF_CYCLE - 24'd1) ? '0 : count_reg + 24'd1;
    if (tick_frame >= mtc_pkg::FRAMES_PER_SECOND) begin
      tick_frame  = '0;
      tick_second = tick_second + 7'd1;
      tick_carry  = mtc_pkg::CARRY_SECOND;
    end
    if (tick_second >= mtc_pkg::SECONDS_PER_MINUTE) begin
      tick_second = '0;
      tick_minute = tick_minute + 7'd1;
      tick_carry  = mtc_pkg::CARRY_MINUTE;
    end
    if (tick_minute >= mtc_pkg::MINUTES_PER_HOUR) begin
      tick_minute = '0;
      tick_hour   = tick_hour + 6'd1;
      tick_carry  = mtc_pkg::CARRY_HOUR;
    end
    if (tick_hour >= mtc_pkg::HOURS_PER_CYCLE) begin
      tick_hour = '0;
    end
  end

  // Next state by opcode; the unused opcode leaves the timecode, phase and count as they are and clears the carry code.
  always_comb begin
    hour_next   = hour_reg;
    minute_next = minute_reg;
    second_next = second_reg;
    frame_next  = frame_reg;
    phase_next  = phase_reg;
    count_next  = count_reg;
    carry_next  = mtc_pkg::CARRY_NONE;
    unique case (item.op)
      mtc_pkg::OP_TICK: begin
        hour_next   = tick_hour[4:0];
        minute_next = tick_minute[5:0];
        second_next = tick_second[5:0];
        frame_next  = tick_frame[4:0];
        phase_next  = phase_reg + 2'd1;
        count_next  = tick_count;
        carry_next  = tick_carry;
      end
      mtc_pkg::OP_LOAD, mtc_pkg::OP_SET: begin
        hour_next   = item.hours & mtc_pkg::HOUR_MASK;
        minute_next = item.minutes;
        second_next = item.seconds;
        frame_next  = item.frames;
        phase_next  = '0;
        count_next  = item.count;
      end
      default: begin
      end
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_reg   <= '0;
      minute_reg <= '0;
      second_reg <= '0;
      frame_reg  <= '0;
      phase_reg  <= '0;
      count_reg  <= '0;
      carry_reg  <= mtc_pkg::CARRY_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (item_ready) begin
        out_valid <= item_valid;
      end
      if (take) begin
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        frame_reg  <= frame_next;
        phase_reg  <= phase_next;
        count_reg  <= count_next;
        carry_reg  <= carry_next;
      end
    end
  end

  assign hours         = hour_reg;
  assign minutes       = minute_reg;
  assign seconds       = second_reg;
  assign frames        = frame_reg;
  assign quarter_phase = phase_reg;
  assign linear_count  = count_reg;
  assign carry_code    = carry_reg;

  a_count_in_cycle: assert property (@(posedge clk) disable iff (rst)
    count_reg < mtc_pkg::QF_CYCLE)
    else $error("linear count left the 32-hour cycle");

  a_carry_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    take && item.op != mtc_pkg::OP_TICK |=> carry_code == mtc_pkg::CARRY_NONE)
    else $error("carry reported for a word that is not a tick");

  a_tick_advances_phase: assert property (@(posedge clk) disable iff (rst)
    take && item.op == mtc_pkg::OP_TICK |=>
      quarter_phase == $past(quarter_phase) + 2'd1)
    else $error("tick did not advance the quarter-frame phase");

endmodule

// ----- rtl/midi_timecode_tracker.sv -----
// Path: an accepted word is registered in the first of the eight conversion
// stages, passes through the later stages in order while no stall holds it,
// and from the last stage loads the state stage that drives the output ports.
// Throughput: one word per cycle while the output is not stalled; a stalled
// result still lets the pipeline fill.
// Reset: timecode 00:00:00:00, phase 0, count 0; pipeline and output emptied.
`timescale 1ns / 1ps

module midi_timecode_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  hour_byte,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  input  logic [4:0]  frame_in,
  input  logic [23:0] linear_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds,
  output logic [4:0]  frames,
  output logic [1:0]  quarter_phase,
  output logic [23:0] linear_count,
  output logic [2:0]  carry_code
);

  mtc_pkg::item_t in_item;
  mtc_pkg::item_t conv_item;
  logic           conv_valid;
  logic           conv_ready;

  // Gather the input word; only the low five bits of the hour byte count.
  always_comb begin
    in_item         = '0;
    in_item.op      = opcode;
    in_item.hours   = hour_byte[4:0] & mtc_pkg::HOUR_MASK;
    in_item.minutes = minute_in;
    in_item.seconds = second_in;
    in_item.frames  = frame_in;
    in_item.count   = linear_in;
  end

  mtc_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_stall   (in_stall),
    .up_item    (in_item),
    .down_valid (conv_valid),
    .down_ready (conv_ready),
    .down_item  (conv_item)
  );

  mtc_state u_state (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (conv_valid),
    .item_ready    (conv_ready),
    .item          (conv_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hours         (hours),
    .minutes       (minutes),
    .seconds       (seconds),
    .frames        (frames),
    .quarter_phase (quarter_phase),
    .linear_count  (linear_count),
    .carry_code    (carry_code)
  );

endmodule
